### hdl/spq_pkg.sv
// Shared types for the sorted priority queue.
// Request and status codes, the cell control word and the result word.
// No dependencies.
`default_nettype none
package spq_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_POP    = 2'd1,
        REQ_PEEK   = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_op;

    typedef struct packed {
        logic [1:0]   status;
        logic         head_valid;
        logic [31:0]  head_data;
        logic [31:0]  head_priority;
        logic [7:0]   entry_count;
    } t_result;

endpackage
`default_nettype wire

### hdl/sorted_priority_queue_top.sv
// Sorted priority queue built as a row of spq_cell slots plus spq_out_buf.
// Depends on spq_pkg, spq_cell and spq_out_buf.
//
// Each request (insert, pop, peek) is handled by all slots at once: every slot compares its
// priority with the new word and shifts toward its neighbor in the same
// cycle, so a new request is accepted on every clock while the result path
// has room. Higher priority values sit nearer the head; equal priorities
// keep arrival order. The result gives the head after the request, a head
// valid flag and the low 8 bits of the entry count; an insert into a full
// queue or a pop of an empty one changes nothing and reports a status code.
// A result word is registered and one more can wait in a skid word, so the
// request side stalls only when both are held.
`default_nettype none
module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_item_data,
    input  wire logic [31:0]        i_item_priority,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_status,
    output logic                    o_head_valid,
    output logic signed [31:0]      o_head_data,
    output logic [31:0]             o_head_priority,
    output logic [7:0]              o_entry_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                  accept;
    logic                  buf_full;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  is_full;
    logic                  is_empty;
    spq_pkg::t_cell_op     op;
    spq_pkg::t_status      status;
    spq_pkg::t_result      res;
    spq_pkg::t_result      out_word;
    logic signed [31:0]    head_data;
    logic [31:0]           head_pri;

    logic                  c_take  [QUEUE_DEPTH];
    logic                  c_valid [QUEUE_DEPTH];
    logic signed [31:0]    c_data  [QUEUE_DEPTH];
    logic [31:0]           c_pri   [QUEUE_DEPTH];

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid & ~buf_full;
    assign is_full    = (r_count == CW'(QUEUE_DEPTH));
    assign is_empty   = (r_count == '0);

    always_comb begin
        op      = '0;
        status  = spq_pkg::ST_DONE;
        n_count = r_count;
        case (i_req_type)
            spq_pkg::REQ_INSERT: begin
                if (is_full) begin
                    status = spq_pkg::ST_FULL;
                end else begin
                    op.ins  = accept;
                    n_count = r_count + 1'b1;
                end
            end
            spq_pkg::REQ_POP: begin
                if (is_empty) begin
                    status = spq_pkg::ST_EMPTY;
                end else begin
                    op.pop  = accept;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                status = spq_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic               prev_valid;
            logic               prev_take;
            logic signed [31:0] prev_data;
            logic [31:0]        prev_pri;
            logic               next_valid;
            logic signed [31:0] next_data;
            logic [31:0]        next_pri;

            if (g == 0) begin : g_head
                assign prev_valid = 1'b1;
                assign prev_take  = 1'b0;
                assign prev_data  = i_item_data;
                assign prev_pri   = i_item_priority;
            end else begin : g_body
                assign prev_valid = c_valid[g-1];
                assign prev_take  = c_take[g-1];
                assign prev_data  = c_data[g-1];
                assign prev_pri   = c_pri[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign next_valid = 1'b0;
                assign next_data  = c_data[g];
                assign next_pri   = c_pri[g];
            end else begin : g_mid
                assign next_valid = c_valid[g+1];
                assign next_data  = c_data[g+1];
                assign next_pri   = c_pri[g+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_op         (op),
                .i_new_data   (i_item_data),
                .i_new_pri    (i_item_priority),
                .i_prev_valid (prev_valid),
                .i_prev_take  (prev_take),
                .i_prev_data  (prev_data),
                .i_prev_pri   (prev_pri),
                .i_next_valid (next_valid),
                .i_next_data  (next_data),
                .i_next_pri   (next_pri),
                .o_take       (c_take[g]),
                .o_valid      (c_valid[g]),
                .o_data       (c_data[g]),
                .o_pri        (c_pri[g])
            );
        end
    endgenerate

    always_comb begin
        head_data = c_data[0];
        head_pri  = c_pri[0];
        if (op.ins && c_take[0]) begin
            head_data = i_item_data;
            head_pri  = i_item_priority;
        end else if (op.pop) begin
            head_data = c_data[1];
            head_pri  = c_pri[1];
        end
        if (n_count == '0) begin
            head_data = '0;
            head_pri  = '0;
        end
    end

    always_comb begin
        res.status        = status;
        res.head_valid    = (n_count != '0);
        res.head_data     = head_data;
        res.head_priority = head_pri;
        res.entry_count   = 8'(n_count);
    end

    spq_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_word  (res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (out_word)
    );

    assign o_status        = out_word.status;
    assign o_head_valid    = out_word.head_valid;
    assign o_head_data     = out_word.head_data;
    assign o_head_priority = out_word.head_priority;
    assign o_entry_count   = out_word.entry_count;

endmodule
`default_nettype wire

### hdl/spq_cell.sv
// One slot of the sorted queue: valid bit, data and priority.
// Exchanges entries with both neighbors; uses spq_pkg.
`default_nettype none
module spq_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire spq_pkg::t_cell_op     i_op,
    input  wire logic signed [31:0]    i_new_data,
    input  wire logic        [31:0]    i_new_pri,
    input  wire logic                  i_prev_valid,
    input  wire logic                  i_prev_take,
    input  wire logic signed [31:0]    i_prev_data,
    input  wire logic        [31:0]    i_prev_pri,
    input  wire logic                  i_next_valid,
    input  wire logic signed [31:0]    i_next_data,
    input  wire logic        [31:0]    i_next_pri,
    output logic                       o_take,
    output logic                       o_valid,
    output logic signed [31:0]         o_data,
    output logic        [31:0]         o_pri
);

    logic               r_valid;
    logic signed [31:0] r_data;
    logic        [31:0] r_pri;
    logic               n_valid;
    logic signed [31:0] n_data;
    logic        [31:0] n_pri;

    assign o_take  = i_op.ins & (~r_valid | (r_pri < i_new_pri));
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_pri   = r_pri;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        n_pri   = r_pri;
        if (i_op.ins) begin
            n_valid = i_prev_valid;
            if (o_take && !i_prev_take) begin
                n_data = i_new_data;
                n_pri  = i_new_pri;
            end else if (o_take) begin
                n_data = i_prev_data;
                n_pri  = i_prev_pri;
            end
        end else if (i_op.pop) begin
            // advance toward the head
            n_valid = i_next_valid;
            n_data  = i_next_data;
            n_pri   = i_next_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_pri  <= n_pri;
    end

endmodule
`default_nettype wire

### hdl/spq_out_buf.sv
// Output register with one skid word for the queue result.
// Uses spq_pkg::t_result.
`default_nettype none
module spq_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire spq_pkg::t_result  i_word,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output spq_pkg::t_result       o_word
);

    logic             r_out_valid;
    logic             r_skd_valid;
    spq_pkg::t_result r_out;
    spq_pkg::t_result r_skd;
    logic             out_free;

    assign out_free = ~r_out_valid | ~i_stall;
    assign o_full   = r_skd_valid;
    assign o_valid  = r_out_valid;
    assign o_word   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_skd_valid | i_load;
            r_skd_valid <= 1'b0;
        end else if (i_load) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skd_valid ? r_skd : i_word;
        end else if (i_load) begin
            r_skd <= i_word;
        end
    end

endmodule
`default_nettype wire

### dv/spq_checker.sv
// Scoreboard for the sorted priority queue: keeps its own ranked list, predicts
// the head word for each accepted request and compares each accepted result.
// Depends on spq_pkg.
`default_nettype none
module spq_checker #(
    parameter int QUEUE_DEPTH = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_item_data,
    input  wire logic [31:0]        i_item_priority,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic [1:0]         i_status,
    input  wire logic               i_head_valid,
    input  wire logic signed [31:0] i_head_data,
    input  wire logic [31:0]        i_head_priority,
    input  wire logic [7:0]         i_entry_count,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_words_checked,
    output int                      o_full_refusals,
    output int                      o_empty_refusals
);

    logic [31:0]       ranked_data [QUEUE_DEPTH];
    logic [31:0]       ranked_priority [QUEUE_DEPTH];
    int                held_entries = 0;
    spq_pkg::t_result  awaited_heads [$];
    int                mismatches = 0;
    int                words_checked = 0;
    int                full_refusals = 0;
    int                empty_refusals = 0;

    function automatic spq_pkg::t_result serve_request(input logic [1:0] req,
                                                       input logic [31:0] dat,
                                                       input logic [31:0] pri);
        spq_pkg::t_result head;
        int               pos;
        head        = '0;
        head.status = spq_pkg::ST_DONE;
        case (req)
            spq_pkg::REQ_INSERT: begin
                if (held_entries >= QUEUE_DEPTH) begin
                    head.status = spq_pkg::ST_FULL;
                end else begin
                    pos = held_entries;
                    while (pos > 0 && ranked_priority[pos - 1] < pri) begin
                        ranked_data[pos]     = ranked_data[pos - 1];
                        ranked_priority[pos] = ranked_priority[pos - 1];
                        pos--;
                    end
                    ranked_data[pos]     = dat;
                    ranked_priority[pos] = pri;
                    held_entries++;
                end
            end
            spq_pkg::REQ_POP: begin
                if (held_entries == 0) begin
                    head.status = spq_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i + 1 < held_entries; i++) begin
                        ranked_data[i]     = ranked_data[i + 1];
                        ranked_priority[i] = ranked_priority[i + 1];
                    end
                    held_entries--;
                end
            end
            default: begin
            end
        endcase
        if (held_entries > 0) begin
            head.head_valid    = 1'b1;
            head.head_data     = ranked_data[0];
            head.head_priority = ranked_priority[0];
        end
        head.entry_count = held_entries[7:0];
        return head;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        spq_pkg::t_result got;
        spq_pkg::t_result want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                got.status        = i_status;
                got.head_valid    = i_head_valid;
                got.head_data     = i_head_data;
                got.head_priority = i_head_priority;
                got.entry_count   = i_entry_count;
                if (awaited_heads.size() == 0) begin
                    $display("%0t: result word with none expected: %h", $time, got);
                    mismatches++;
                end else begin
                    want = awaited_heads.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
                    check_field("head_data", want.head_data, got.head_data);
                    check_field("head_priority", want.head_priority, got.head_priority);
                    check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                    words_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = serve_request(i_req_type, i_item_data, i_item_priority);
                if (want.status == spq_pkg::ST_FULL) full_refusals++;
                if (want.status == spq_pkg::ST_EMPTY) empty_refusals++;
                awaited_heads.push_back(want);
            end
        end
        o_fail_count     <= mismatches;
        o_pending        <= awaited_heads.size();
        o_words_checked  <= words_checked;
        o_full_refusals  <= full_refusals;
        o_empty_refusals <= empty_refusals;
    end

endmodule
`default_nettype wire

### dv/tb_sorted_priority_queue_top.sv
// Testbench top for the sorted priority queue: clock, reset, request stimulus
// with random idling on both channels, and the verdict.
// Depends on spq_pkg, sorted_priority_queue_top and spq_checker.
`default_nettype none
module tb_sorted_priority_queue_top;

    localparam int          QUEUE_DEPTH = 128;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type = spq_pkg::REQ_PEEK;
    logic signed [31:0] item_data = '0;
    logic [31:0]        item_priority = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic               head_valid;
    logic signed [31:0] head_data;
    logic [31:0]        head_priority;
    logic [7:0]         entry_count;

    int fail_count;
    int pending;
    int words_checked;
    int full_refusals;
    int empty_refusals;
    int cycles = 0;
    bit idling = 1'b1;

    always #1 clk = ~clk;

    sorted_priority_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_req_type     (req_type),
        .i_item_data    (item_data),
        .i_item_priority(item_priority),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_head_valid   (head_valid),
        .o_head_data    (head_data),
        .o_head_priority(head_priority),
        .o_entry_count  (entry_count)
    );

    spq_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) queue_scoreboard (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_req_type      (req_type),
        .i_item_data     (item_data),
        .i_item_priority (item_priority),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_status        (status),
        .i_head_valid    (head_valid),
        .i_head_data     (head_data),
        .i_head_priority (head_priority),
        .i_entry_count   (entry_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked),
        .o_full_refusals (full_refusals),
        .o_empty_refusals(empty_refusals)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_sorted_priority_queue_top NOT OK");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] req, input logic [31:0] dat,
                             input logic [31:0] pri);
        if (idling && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= req;
        item_data     <= dat;
        item_priority <= pri;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_priority(input bit narrow);
        if (narrow) return $urandom_range(0, 7);
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input int words, input int insert_pct, input int pop_pct,
                             input bit narrow);
        int         roll;
        logic [1:0] req;
        for (int n = 0; n < words; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) req = spq_pkg::REQ_INSERT;
            else if (roll < insert_pct + pop_pct) req = spq_pkg::REQ_POP;
            else if ($urandom_range(0, 1) == 0) req = spq_pkg::REQ_PEEK;
            else req = REQ_UNUSED;
            send_word(req, pick_data(), pick_priority(narrow));
        end
    endtask

    initial begin
        int run;
        @(posedge rst_n);
        forever begin
            if (idling && $urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_stall <= 1'b0;
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(1, 24);
            repeat (run) @(posedge clk);
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(spq_pkg::REQ_PEEK,   32'h0, 32'h0);
        send_word(spq_pkg::REQ_POP,    32'h0, 32'h0);
        send_word(REQ_UNUSED,          32'h0, 32'h0);
        send_word(spq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(spq_pkg::REQ_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(spq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(spq_pkg::REQ_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_word(spq_pkg::REQ_INSERT, 32'h0000_0001, 32'h0000_0005);
        send_word(spq_pkg::REQ_PEEK,   32'h0, 32'h0);
        send_word(REQ_UNUSED,          32'h0, 32'h0);
        send_word(spq_pkg::REQ_INSERT, 32'h0000_0002, 32'h0000_0005);
        repeat (7) send_word(spq_pkg::REQ_POP, 32'h0, 32'h0);
        send_word(spq_pkg::REQ_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
        send_word(spq_pkg::REQ_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_word(spq_pkg::REQ_POP,    32'h0, 32'h0);
        send_word(spq_pkg::REQ_POP,    32'h0, 32'h0);

        run_phase(150, 50, 35, 1'b0);
        run_phase(180, 92, 4, 1'b1);
        run_phase(60, 50, 45, 1'b0);
        run_phase(180, 4, 92, 1'b0);
        run_phase(170, 90, 5, 1'b1);
        idling = 1'b0;
        run_phase(100, 45, 45, 1'b0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d result words checked; %0d inserts refused at full, %0d pops refused at empty",
                 words_checked, full_refusals, empty_refusals);
        if (fail_count == 0) begin
            $display("tb_sorted_priority_queue_top OK");
        end else begin
            $display("tb_sorted_priority_queue_top NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
